### hdl/bole_pkg.sv
// Shared types and constants for the bounded ordered list engine.
// No dependencies; imported by bole_ctrl and the top level.
`default_nettype none
package bole_pkg;

  localparam int DEPTH = 32;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;

  // request codes
  localparam logic [2:0] REQ_INS_HEAD = 3'd0;
  localparam logic [2:0] REQ_INS_TAIL = 3'd1;
  localparam logic [2:0] REQ_INS_POS  = 3'd2;
  localparam logic [2:0] REQ_DEL_HEAD = 3'd3;
  localparam logic [2:0] REQ_DEL_TAIL = 3'd4;
  localparam logic [2:0] REQ_DEL_VAL  = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_BADPOS   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [2:0]        req_type;
    logic signed [31:0] value;
    logic [5:0]        position;
  } req_word_t;

  typedef struct packed {
    logic [2:0]        status;
    logic signed [31:0] removed_value;
    logic [5:0]        entry_count;
  } rsp_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHDN,
    S_SHUP,
    S_RES
  } ctrl_state_t;

endpackage
`default_nettype wire

### hdl/bole_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module bole_ram #(
  parameter int DATA_W = 32,
  parameter int WORDS  = 32,
  parameter int ADDR_W = $clog2(WORDS)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hdl/bole_ctrl.sv
// Request sequencer: decodes a request, walks the list memory to scan or
// shift entries, and hands one result word to the output stage.
// Depends on bole_pkg and bole_ram.
`default_nettype none
module bole_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire bole_pkg::req_word_t req,
  output logic                   res_valid,
  input  wire logic              res_take,
  output bole_pkg::rsp_word_t    res
);
  import bole_pkg::*;

  ctrl_state_t state, state_next;

  logic [CW-1:0]        cnt;
  logic [AW-1:0]        ptr;
  logic [AW-1:0]        at;
  logic [CW-1:0]        rem;
  logic                 pend;
  logic [AW-1:0]        pend_addr;
  logic [2:0]           status_r;
  logic [DW-1:0]        removed_r;
  logic [DW-1:0]        val_r;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [DW-1:0]        mem_wdata;
  logic                 mem_re;
  logic [DW-1:0]        mem_rdata;

  logic                 accept;
  logic                 full;
  logic                 empty;
  logic                 pos_bad;
  logic                 hit;
  logic                 walk_done;
  logic [CW:0]          pos_ext;
  logic [CW:0]          lim_ext;
  logic [AW-1:0]        ins_at;

  bole_ram #(.DATA_W(DW), .WORDS(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (ptr),
    .rdata (mem_rdata)
  );

  assign accept    = req_valid && !req_stall;
  assign full      = (cnt >= CW'(DEPTH));
  assign empty     = (cnt == '0);
  // position range check done one bit wider than the count
  assign pos_ext   = (CW + 1)'(req.position);
  assign lim_ext   = (CW + 1)'(cnt) + (CW + 1)'(1);
  assign pos_bad   = (req.position == '0) || (pos_ext > lim_ext);
  assign hit       = pend && (mem_rdata == val_r);
  assign walk_done = !pend && (rem == '0);

  always_comb begin
    case (req.req_type)
      REQ_INS_HEAD: ins_at = '0;
      REQ_INS_TAIL: ins_at = AW'(cnt);
      default:      ins_at = AW'(req.position - 6'd1);
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.req_type)
            REQ_INS_HEAD, REQ_INS_TAIL: state_next = full ? S_RES : S_SHUP;
            REQ_INS_POS:  state_next = (full || pos_bad) ? S_RES : S_SHUP;
            REQ_DEL_HEAD, REQ_DEL_TAIL: state_next = empty ? S_RES : S_SHDN;
            REQ_DEL_VAL:  state_next = empty ? S_RES : S_SCAN;
            default:      state_next = S_RES;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_next = S_SHDN;
        end else if (walk_done) begin
          state_next = S_RES;
        end
      end
      S_SHDN, S_SHUP: begin
        if (walk_done) begin
          state_next = S_RES;
        end
      end
      S_RES: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and memory port control
  always_comb begin
    req_stall = (state != S_IDLE);
    res_valid = (state == S_RES);
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pend_addr;
    mem_wdata = mem_rdata;
    case (state)
      S_SCAN: begin
        mem_re = (rem != '0);
      end
      S_SHDN: begin
        mem_re    = (rem != '0);
        mem_we    = pend && (pend_addr != at);
        mem_waddr = pend_addr - AW'(1);
      end
      S_SHUP: begin
        mem_re = (rem != '0);
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr + AW'(1);
        end else if (rem == '0) begin
          mem_we    = 1'b1;
          mem_waddr = at;
          mem_wdata = val_r;
        end
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= mem_re;
      if (state == S_SHDN && walk_done) begin
        cnt <= cnt - CW'(1);
      end else if (state == S_SHUP && walk_done) begin
        cnt <= cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= ptr;
    if (mem_re) begin
      rem <= rem - CW'(1);
      ptr <= (state == S_SHUP) ? ptr - AW'(1) : ptr + AW'(1);
    end
    case (state)
      S_IDLE: begin
        if (accept) begin
          val_r     <= req.value;
          removed_r <= '0;
          status_r  <= ST_OK;
          case (req.req_type)
            REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
              at  <= ins_at;
              ptr <= AW'(cnt - CW'(1));
              rem <= cnt - CW'(ins_at);
              if (full) begin
                status_r <= ST_FULL;
              end else if (req.req_type == REQ_INS_POS && pos_bad) begin
                status_r <= ST_BADPOS;
              end
            end
            REQ_DEL_HEAD: begin
              at  <= '0;
              ptr <= '0;
              rem <= cnt;
              if (empty) status_r <= ST_EMPTY;
            end
            REQ_DEL_TAIL: begin
              at  <= AW'(cnt - CW'(1));
              ptr <= AW'(cnt - CW'(1));
              rem <= CW'(1);
              if (empty) status_r <= ST_EMPTY;
            end
            REQ_DEL_VAL: begin
              ptr <= '0;
              rem <= cnt;
              if (empty) status_r <= ST_EMPTY;
            end
            default: begin
              status_r <= ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          at        <= pend_addr;
          removed_r <= mem_rdata;
        end else if (walk_done) begin
          status_r <= ST_NOTFOUND;
        end
      end
      S_SHDN: begin
        if (pend && pend_addr == at) begin
          removed_r <= mem_rdata;
        end
      end
      default: begin
        status_r <= status_r;
      end
    endcase
  end

  assign res.status        = status_r;
  assign res.removed_value = removed_r;
  assign res.entry_count   = 6'(cnt);

endmodule
`default_nettype wire

### hdl/bounded_ordered_list_engine.sv
// Top level of the bounded ordered list engine: request sequencer plus
// the registered response stage. Depends on bole_pkg and bole_ctrl.
// Usage:
//   Requests enter on req / req_valid / req_stall; a word is taken at a
//   clock edge with req_valid high and req_stall low. Each request gives
//   exactly one response word on rsp / rsp_valid / rsp_stall.
//   The list lives in one DEPTH-entry memory, head at entry 0. Inserts shift
//   later entries up, deletes shift them down, one read and one write a cycle.
//   Rejected requests (full, empty, bad position, unused code) go straight
//   to the response with no memory walk; other inserts and deletes shift
//   entries over the memory port, a delete by value first scanning for its
//   value, so the memory port walk sets the time to the response.
//   One request is in work at a time; the next is taken in the cycle after
//   the previous response leaves the sequencer, even while that response
//   still waits in the output register.
//   Reset (rst, synchronous) empties the list and drops any response.
//   While rsp_stall is high the response word holds; a finished request
//   waits in the sequencer until the output register frees up.
`default_nettype none
module bounded_ordered_list_engine (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire bole_pkg::req_word_t req,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output bole_pkg::rsp_word_t      rsp
);
  import bole_pkg::*;

  logic      res_valid;
  logic      res_take;
  rsp_word_t res;

  bole_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // load the output register when it is empty or being drained
  assign res_take = res_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp <= res;
    end
  end

endmodule
`default_nettype wire
